FILE: hw/rtl/cspg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cspg_pkg: shared types and constants of the conic/spiral gradient generator
// Fixed-point widths, CORDIC arctangent table, register codes and the
// structures that travel between the front end, the queues and the back end.
// ----------------------------------------------------------------------------
package cspg_pkg;

    localparam int SZ_W  = 13;  // clamped image size, up to MAX_IMAGE_SIZE (2048 by default)
    localparam int RM_W  = 12;  // divider remainder, always below the size
    localparam int D_W   = 14;  // signed pixel offset from the center
    localparam int XW    = 32;  // vectoring CORDIC datapath, Q16 pixels
    localparam int ZW    = 24;  // angles in Q24 turns
    localparam int RW    = 30;  // radius in Q16 pixels
    localparam int NW    = 40;  // spiral dividend
    localparam int SW    = 26;  // signed residual angle of the sine CORDIC
    localparam int YW    = 32;  // sine datapath in Q30
    localparam int STEPS = 20;

    localparam logic [ZW-1:0]        HALF_TURN    = 24'h800000;
    localparam logic signed [SW-1:0] FULL_S       = 26'sd16777216;
    localparam logic signed [SW-1:0] HALF_S       = 26'sd8388608;
    localparam logic signed [SW-1:0] QUART_S      = 26'sd4194304;
    localparam logic [15:0]          INV_GAIN_Q16 = 16'd39797;
    localparam logic signed [YW-1:0] INV_GAIN_Q30 = 32'sd652032874;
    localparam logic [24:0]          SPIRAL_K     = 25'd26701770;
    localparam logic [SZ_W-1:0]      MIN_SIZE     = 13'd64;

    typedef enum logic [2:0] {
        REG_IMAGE_SIZE,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_GRADIENT_MODE,
        REG_PHASE_OFFSET,
        REG_RIPPLE_FREQ,
        REG_RIPPLE_AMP,
        REG_MIRROR_ENABLE
    } cspg_reg_t;

    typedef struct packed {
        logic [SZ_W-1:0] size;
        logic [11:0]     cx;
        logic [11:0]     cy;
        logic            mode;
        logic [15:0]     offset;
        logic [15:0]     rf;
        logic [15:0]     amp;
        logic            mirror;
    } cspg_cfg_t;

    typedef struct packed {
        logic                   wr;
        logic [9:0]             idx;
        logic [23:0]            col;
        logic signed [D_W-1:0]  dx;
        logic signed [D_W-1:0]  dy;
    } cspg_item_t;

    typedef struct packed {
        logic        wr;
        logic [9:0]  idx;
        logic [23:0] col;
    } cspg_tag_t;

    function automatic logic [ZW-1:0] atan_q24(input int i);
        logic [ZW-1:0] v;
        case (i)
            0:  v = 24'd2097152;
            1:  v = 24'd1238021;
            2:  v = 24'd654136;
            3:  v = 24'd332050;
            4:  v = 24'd166669;
            5:  v = 24'd83416;
            6:  v = 24'd41718;
            7:  v = 24'd20860;
            8:  v = 24'd10430;
            9:  v = 24'd5215;
            10: v = 24'd2608;
            11: v = 24'd1304;
            12: v = 24'd652;
            13: v = 24'd326;
            14: v = 24'd163;
            15: v = 24'd81;
            16: v = 24'd41;
            17: v = 24'd20;
            18: v = 24'd10;
            19: v = 24'd5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/conic_spiral_gradient_pixel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conic_spiral_gradient_pixel: conic and spiral gradient pixel generator
// Turns pixel coordinates into colors from a loadable 24-bit color table.
// ----------------------------------------------------------------------------
// Input channel: push a transaction while full is low. command 0 computes the
// color of (pixel_x, pixel_y); command 1 writes entry_index of the color table
// and gives no result. Results appear on out_red/out_green/out_blue while
// empty is low and are taken with pop.
// Throughput is one transaction per cycle while the pipeline is not stalled. A
// pixel passes through a 4-entry input queue, 21 vectoring CORDIC stages,
// 2 multiply stages, 21 stages shared by the two-bit-per-stage spiral
// divider and the ripple sine CORDIC, 3 phase and index stages, the table
// read and a 2-entry output queue.
// When pop stays low the output queue fills, the pipeline holds, the input
// queue fills and full rises; nothing is dropped.
// Reset empties both queues and the pipeline and loads the register defaults.
// The color table is not cleared; an entry must be written before it is used.
// The user writes registers over APB only with no transaction open; unenforced.
// ----------------------------------------------------------------------------
module conic_spiral_gradient_pixel
    import cspg_pkg::*;
#(
    parameter int TABLE_ENTRIES  = 1024,
    parameter int MAX_IMAGE_SIZE = 2048,
    parameter int PHASE_BITS     = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [10:0] pixel_x,
    input  logic [10:0] pixel_y,
    input  logic [9:0]  entry_index,
    input  logic [7:0]  entry_red,
    input  logic [7:0]  entry_green,
    input  logic [7:0]  entry_blue,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue
);

    logic [11:0] image_size_reg;
    logic [11:0] center_x_reg;
    logic [11:0] center_y_reg;
    logic        gradient_mode_reg;
    logic [15:0] phase_offset_reg;
    logic [15:0] ripple_freq_reg;
    logic [15:0] ripple_amp_reg;
    logic        mirror_reg;

    cspg_cfg_t   cfg;
    cspg_reg_t   sel;
    logic        wr_en;
    logic [SZ_W-1:0] size_ext;

    cspg_item_t  fe_item;
    logic        fe_keep;
    logic        iq_full;
    logic        iq_empty;
    logic [$bits(cspg_item_t)-1:0] iq_rdata;
    cspg_item_t  iq_item;
    logic        bk_take;
    logic        bk_push;
    logic [23:0] bk_color;
    logic        oq_full;
    logic [23:0] oq_rdata;

    assign pready = 1'b1;
    assign sel    = cspg_reg_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg    <= 12'd512;
            center_x_reg      <= 12'd256;
            center_y_reg      <= 12'd256;
            gradient_mode_reg <= 1'b0;
            phase_offset_reg  <= '0;
            ripple_freq_reg   <= '0;
            ripple_amp_reg    <= '0;
            mirror_reg        <= 1'b0;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_IMAGE_SIZE:    image_size_reg    <= pwdata[11:0];
                REG_CENTER_X:      center_x_reg      <= pwdata[11:0];
                REG_CENTER_Y:      center_y_reg      <= pwdata[11:0];
                REG_GRADIENT_MODE: gradient_mode_reg <= pwdata[0];
                REG_PHASE_OFFSET:  phase_offset_reg  <= pwdata[15:0];
                REG_RIPPLE_FREQ:   ripple_freq_reg   <= pwdata[15:0];
                REG_RIPPLE_AMP:    ripple_amp_reg    <= pwdata[15:0];
                REG_MIRROR_ENABLE: mirror_reg        <= pwdata[0];
                default:           mirror_reg        <= mirror_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_IMAGE_SIZE:    prdata = {20'b0, image_size_reg};
            REG_CENTER_X:      prdata = {20'b0, center_x_reg};
            REG_CENTER_Y:      prdata = {20'b0, center_y_reg};
            REG_GRADIENT_MODE: prdata = {31'b0, gradient_mode_reg};
            REG_PHASE_OFFSET:  prdata = {16'b0, phase_offset_reg};
            REG_RIPPLE_FREQ:   prdata = {16'b0, ripple_freq_reg};
            REG_RIPPLE_AMP:    prdata = {16'b0, ripple_amp_reg};
            REG_MIRROR_ENABLE: prdata = {31'b0, mirror_reg};
            default:           prdata = '0;
        endcase
    end

    // Image size is clamped to the supported range before any use.
    always_comb
    begin
        size_ext = {1'b0, image_size_reg};
        if (size_ext < MIN_SIZE)
        begin
            cfg.size = MIN_SIZE;
        end
        else if (size_ext > SZ_W'(MAX_IMAGE_SIZE))
        begin
            cfg.size = SZ_W'(MAX_IMAGE_SIZE);
        end
        else
        begin
            cfg.size = size_ext;
        end
        cfg.cx     = center_x_reg;
        cfg.cy     = center_y_reg;
        cfg.mode   = gradient_mode_reg;
        cfg.offset = phase_offset_reg;
        cfg.rf     = ripple_freq_reg;
        cfg.amp    = ripple_amp_reg;
        cfg.mirror = mirror_reg;
    end

    cspg_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .cfg         (cfg),
        .command     (command),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .entry_index (entry_index),
        .entry_red   (entry_red),
        .entry_green (entry_green),
        .entry_blue  (entry_blue),
        .item        (fe_item),
        .keep        (fe_keep)
    );

    assign full = iq_full;

    cspg_queue #(
        .WIDTH ($bits(cspg_item_t)),
        .DEPTH (4)
    ) u_in_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && fe_keep),
        .wdata (fe_item),
        .pop   (bk_take),
        .rdata (iq_rdata),
        .full  (iq_full),
        .empty (iq_empty)
    );

    assign iq_item = iq_rdata;

    cspg_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PHASE_BITS    (PHASE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .item      (iq_item),
        .item_vld  (!iq_empty),
        .take      (bk_take),
        .res_push  (bk_push),
        .res_color (bk_color),
        .res_full  (oq_full)
    );

    cspg_queue #(
        .WIDTH (24),
        .DEPTH (2)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (bk_push),
        .wdata (bk_color),
        .pop   (pop),
        .rdata (oq_rdata),
        .full  (oq_full),
        .empty (empty)
    );

    assign out_red   = oq_rdata[23:16];
    assign out_green = oq_rdata[15:8];
    assign out_blue  = oq_rdata[7:0];

endmodule
`default_nettype wire

FILE: hw/rtl/cspg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cspg_front: transaction classifier
// Separates table writes from pixel computations, drops writes beyond the
// table, applies the horizontal mirror and forms the offsets from the center.
// ----------------------------------------------------------------------------
module cspg_front
    import cspg_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024
)
(
    input  cspg_cfg_t   cfg,
    input  logic        command,
    input  logic [10:0] pixel_x,
    input  logic [10:0] pixel_y,
    input  logic [9:0]  entry_index,
    input  logic [7:0]  entry_red,
    input  logic [7:0]  entry_green,
    input  logic [7:0]  entry_blue,
    output cspg_item_t  item,
    output logic        keep
);

    logic signed [14:0] x15;
    logic signed [14:0] y15;
    logic signed [14:0] sz15;
    logic signed [14:0] h15;
    logic signed [14:0] cx15;
    logic signed [14:0] cy15;
    logic signed [14:0] px15;
    logic signed [14:0] dx15;
    logic signed [14:0] dy15;

    always_comb
    begin
        x15  = $signed({4'b0, pixel_x});
        y15  = $signed({4'b0, pixel_y});
        sz15 = $signed({2'b0, cfg.size});
        h15  = $signed({3'b0, cfg.size[SZ_W-1:1]});
        cx15 = ($signed({3'b0, cfg.cx}) > sz15) ? sz15 : $signed({3'b0, cfg.cx});
        cy15 = ($signed({3'b0, cfg.cy}) > sz15) ? sz15 : $signed({3'b0, cfg.cy});

        // Mirror: the left half is flipped, the right half repeats it.
        if (cfg.mirror)
        begin
            px15 = sz15 - 15'sd1 - x15;
            if ((x15 >= h15) && (x15 < (h15 <<< 1)))
            begin
                px15 = px15 + h15;
            end
        end
        else
        begin
            px15 = x15;
        end

        dx15 = px15 - cx15;
        dy15 = y15 - cy15;

        item.wr  = command;
        item.idx = entry_index;
        item.col = {entry_red, entry_green, entry_blue};
        item.dx  = dx15[D_W-1:0];
        item.dy  = dy15[D_W-1:0];

        keep = !command || (32'(entry_index) < TABLE_ENTRIES);
    end

endmodule
`default_nettype wire

FILE: hw/rtl/cspg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cspg_queue: small first-in first-out queue
// Register-based queue with show-ahead read data and registered status.
// ----------------------------------------------------------------------------
module cspg_queue
    import cspg_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/cspg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cspg_back: gradient pipeline and color table
// Vectoring CORDIC for angle and radius, then a shared stage row that runs the
// spiral divider and the ripple sine CORDIC side by side, phase assembly,
// table lookup and table writes, all under one stall enable.
// ----------------------------------------------------------------------------
module cspg_back
    import cspg_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024,
    parameter int PHASE_BITS    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cspg_cfg_t   cfg,
    input  cspg_item_t  item,
    input  logic        item_vld,
    output logic        take,
    output logic        res_push,
    output logic [23:0] res_color,
    input  logic        res_full
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int TW = $clog2(TABLE_ENTRIES + 1);
    localparam int L  = 2*STEPS + 7;

    logic            en;
    logic [L-1:0]    vld_reg;
    cspg_tag_t       tag_reg [L];

    logic signed [XW-1:0] cx_reg [STEPS+1];
    logic signed [XW-1:0] cy_reg [STEPS+1];
    logic [ZW-1:0]        cz_reg [STEPS+1];
    logic                 zero_reg [STEPS+1];

    logic [RW-1:0]        rad_reg;
    logic [ZW-1:0]        ang1_reg;
    logic [NW-1:0]        n_reg;
    logic [ZW-1:0]        arg_reg;
    logic [ZW-1:0]        ang2_reg;

    logic [NW-1:0]        dn_reg   [STEPS+1];
    logic [RM_W-1:0]      drem_reg [STEPS+1];
    logic [ZW-1:0]        dq_reg   [STEPS+1];
    logic signed [SW-1:0] ds_reg   [STEPS+1];
    logic signed [YW-1:0] dx_reg   [STEPS+1];
    logic signed [YW-1:0] dy_reg   [STEPS+1];
    logic [ZW-1:0]        dang_reg [STEPS+1];

    logic [ZW-1:0]        sh_reg;
    logic [ZW-1:0]        sp_reg;
    logic [ZW-1:0]        ang3_reg;
    logic [ZW-1:0]        acc_reg;
    logic [IW-1:0]        idx_reg;

    logic [23:0]          table_reg [TABLE_ENTRIES];
    logic [23:0]          rdata_reg;
    logic                 res_vld_reg;

    logic signed [XW-1:0] dxs;
    logic signed [XW-1:0] dys;
    logic [XW+15:0]       p_rad;
    logic [RW+25:0]       p_n;
    logic [RW+15:0]       p_arg;
    logic signed [SW-1:0] sa;
    logic signed [SW-1:0] sf;
    logic signed [YW+16:0] p_sh;
    logic [PHASE_BITS+TW-1:0] p_idx;
    logic                 rd_fire;
    logic                 wr_fire;

    // The whole pipeline stalls only when a result waits and the output is full.
    assign en        = !(res_vld_reg && res_full);
    assign take      = en;
    assign res_push  = en && res_vld_reg;
    assign res_color = rdata_reg;
    assign rd_fire   = vld_reg[L-1] && !tag_reg[L-1].wr;
    assign wr_fire   = vld_reg[L-1] && tag_reg[L-1].wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            res_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[L-2:0], item_vld};
            res_vld_reg <= rd_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= '{wr: item.wr, idx: item.idx, col: item.col};
            for (int k = 1; k < L; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // Vectoring CORDIC setup: left half-plane points are turned by half a turn.
    always_comb
    begin
        dxs = {{(XW-D_W-16){item.dx[D_W-1]}}, item.dx, 16'b0};
        dys = {{(XW-D_W-16){item.dy[D_W-1]}}, item.dy, 16'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0]   <= item.dx[D_W-1] ? -dxs : dxs;
            cy_reg[0]   <= item.dx[D_W-1] ? -dys : dys;
            cz_reg[0]   <= item.dx[D_W-1] ? HALF_TURN : '0;
            zero_reg[0] <= (item.dx == '0) && (item.dy == '0);
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_vec
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (!cy_reg[i][XW-1])
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + atan_q24(i);
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - atan_q24(i);
                end
            end
        end
    end

    assign p_rad = $unsigned(cx_reg[STEPS]) * INV_GAIN_Q16;
    assign p_n   = rad_reg * SPIRAL_K;
    assign p_arg = rad_reg * cfg.rf;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= p_rad[16 +: RW];
            ang1_reg <= zero_reg[STEPS] ? '0 : cz_reg[STEPS];
            n_reg    <= p_n[16 +: NW];
            arg_reg  <= p_arg[8 +: ZW];
            ang2_reg <= ang1_reg;
        end
    end

    // Fold the ripple argument into plus or minus a quarter turn.
    always_comb
    begin
        sa = $signed({2'b00, arg_reg}) - (arg_reg[ZW-1] ? FULL_S : '0);
        if (sa > QUART_S)
        begin
            sf = HALF_S - sa;
        end
        else if (sa < -QUART_S)
        begin
            sf = -HALF_S - sa;
        end
        else
        begin
            sf = sa;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dn_reg[0]   <= n_reg;
            drem_reg[0] <= '0;
            dq_reg[0]   <= '0;
            ds_reg[0]   <= sf;
            dx_reg[0]   <= INV_GAIN_Q30;
            dy_reg[0]   <= '0;
            dang_reg[0] <= ang2_reg;
        end
    end

    // Each stage retires two quotient bits and one sine rotation.
    for (genvar k = 0; k < STEPS; k++)
    begin : g_div
        logic [SZ_W-1:0] t1;
        logic [SZ_W-1:0] t2;
        logic [SZ_W-1:0] r1;
        logic [SZ_W-1:0] r2;
        logic            ge1;
        logic            ge2;

        always_comb
        begin
            t1  = {drem_reg[k], dn_reg[k][NW-1]};
            ge1 = (t1 >= cfg.size);
            r1  = ge1 ? (t1 - cfg.size) : t1;
            t2  = {r1[RM_W-1:0], dn_reg[k][NW-2]};
            ge2 = (t2 >= cfg.size);
            r2  = ge2 ? (t2 - cfg.size) : t2;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dn_reg[k+1]   <= {dn_reg[k][NW-3:0], 2'b00};
                drem_reg[k+1] <= r2[RM_W-1:0];
                dq_reg[k+1]   <= {dq_reg[k][ZW-3:0], ge1, ge2};
                dang_reg[k+1] <= dang_reg[k];
                if (!ds_reg[k][SW-1])
                begin
                    dx_reg[k+1] <= dx_reg[k] - (dy_reg[k] >>> k);
                    dy_reg[k+1] <= dy_reg[k] + (dx_reg[k] >>> k);
                    ds_reg[k+1] <= ds_reg[k] - $signed({2'b00, atan_q24(k)});
                end
                else
                begin
                    dx_reg[k+1] <= dx_reg[k] + (dy_reg[k] >>> k);
                    dy_reg[k+1] <= dy_reg[k] - (dx_reg[k] >>> k);
                    ds_reg[k+1] <= ds_reg[k] + $signed({2'b00, atan_q24(k)});
                end
            end
        end
    end

    assign p_sh  = dy_reg[STEPS] * $signed({1'b0, cfg.amp});
    assign p_idx = acc_reg[ZW-1 -: PHASE_BITS] * TW'(TABLE_ENTRIES);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_reg   <= p_sh[22 +: ZW];
            sp_reg   <= dq_reg[STEPS];
            ang3_reg <= dang_reg[STEPS];
            if (cfg.mode)
            begin
                acc_reg <= ang3_reg + {cfg.offset, 8'b0} + sp_reg;
            end
            else if (cfg.rf != '0)
            begin
                acc_reg <= ang3_reg + {cfg.offset, 8'b0} + sh_reg;
            end
            else
            begin
                acc_reg <= ang3_reg + {cfg.offset, 8'b0};
            end
            idx_reg <= p_idx[PHASE_BITS +: IW];
        end
    end

    // Writes and reads share one port; they stay in transaction order.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (wr_fire)
            begin
                table_reg[IW'(tag_reg[L-1].idx)] <= tag_reg[L-1].col;
            end
            if (rd_fire)
            begin
                rdata_reg <= table_reg[idx_reg];
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full output queue");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> res_vld_reg)
        else $error("pending result lost during a stall");

    a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_fire && en) |=> res_vld_reg)
        else $error("table read did not produce a result");

endmodule
`default_nettype wire
